### rtl/isms_pkg.sv
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types, status codes and helpers for the interval set merge table.
// ----------------------------------------------------------------------------
package isms_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_member;
        logic        all_at_or_below;
        logic [6:0]  interval_count;
        logic [32:0] member_total;
    } t_result;

    // Number of integers in [lo, hi], hi not below lo.
    function automatic logic [32:0] f_span(logic signed [31:0] lo, logic signed [31:0] hi);
        logic [32:0] diff;
        diff = {hi[31], hi} - {lo[31], lo};
        return diff + 33'd1;
    endfunction

endpackage

### rtl/isms_mem.sv
// ----------------------------------------------------------------------------
// isms_mem
// Interval table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module isms_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  isms_pkg::t_entry  i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output isms_pkg::t_entry  o_rdata
);
    import isms_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/isms_ctrl.sv
// ----------------------------------------------------------------------------
// isms_ctrl
// Sequencer that scans the interval table for a query, or for an insert merges
// or opens a slot, shifts the tail of the table and writes the new interval back.
// ----------------------------------------------------------------------------
module isms_ctrl #(
    parameter int MAX_INTERVALS = 64,
    parameter int IW            = 6,
    parameter int CW            = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  logic                i_op,
    input  logic signed [31:0]  i_low_end,
    input  logic signed [31:0]  i_high_end,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output isms_pkg::t_result   o_res,
    output logic                o_rd_en,
    output logic [IW-1:0]       o_rd_addr,
    input  isms_pkg::t_entry    i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output isms_pkg::t_entry    o_wr_data
);
    import isms_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    logic [2:0]          r_state, n_state;
    logic                r_op, n_op;
    logic signed [31:0]  r_a, n_a;
    logic signed [32:0]  r_am1, n_am1;
    logic signed [32:0]  r_bp1, n_bp1;
    logic signed [31:0]  r_lo, n_lo;
    logic signed [31:0]  r_hi, n_hi;
    logic [CW-1:0]       r_used, n_used;
    logic [32:0]         r_total, n_total;
    logic [32:0]         r_gone, n_gone;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_pidx, n_pidx;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_removed, n_removed;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_dm1, n_dm1;
    logic                r_up, n_up;
    logic                r_member, n_member;
    logic                r_below, n_below;
    logic [1:0]          r_status, n_status;

    logic                w_left;
    logic                w_right;
    logic                w_stop;
    logic [CW-1:0]       w_dst;
    logic [CW+6:0]       w_count_ext;

    assign w_left  = $signed({i_rd_data.hi[31], i_rd_data.hi}) < r_am1;
    assign w_right = $signed({i_rd_data.lo[31], i_rd_data.lo}) > r_bp1;
    assign w_stop  = r_pend && (r_op == OP_INSERT) && !w_left && w_right;
    assign w_dst   = r_up ? (r_pidx + CW'(1)) : (r_pidx - r_dm1);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_a       = r_a;
        n_am1     = r_am1;
        n_bp1     = r_bp1;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_used    = r_used;
        n_total   = r_total;
        n_gone    = r_gone;
        n_k       = r_k;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_i       = r_i;
        n_removed = r_removed;
        n_cnt     = r_cnt;
        n_dm1     = r_dm1;
        n_up      = r_up;
        n_member  = r_member;
        n_below   = r_below;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_k[IW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_i[IW-1:0];
        o_wr_data = '{hi: r_hi, lo: r_lo};

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_op      = i_op;
                    n_a       = i_low_end;
                    n_am1     = {i_low_end[31], i_low_end} - 33'sd1;
                    n_bp1     = {i_high_end[31], i_high_end} + 33'sd1;
                    n_lo      = i_low_end;
                    n_hi      = i_high_end;
                    n_k       = '0;
                    n_pend    = 1'b0;
                    n_i       = '0;
                    n_removed = '0;
                    n_gone    = '0;
                    n_member  = 1'b0;
                    n_below   = (i_op == OP_QUERY) && (r_used == '0);
                    n_status  = ST_OK;
                    if ((i_op == OP_INSERT) && (i_low_end > i_high_end)) begin
                        n_status = ST_ORDER;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = 1'b0;
                if ((r_k < r_used) && !w_stop) begin
                    o_rd_en = 1'b1;
                    n_k     = r_k + CW'(1);
                    n_pend  = 1'b1;
                    n_pidx  = r_k;
                end
                if (r_pend) begin
                    if (r_op == OP_QUERY) begin
                        if ((i_rd_data.lo <= r_a) && (r_a <= i_rd_data.hi)) begin
                            n_member = 1'b1;
                        end
                        if (r_pidx == (r_used - CW'(1))) begin
                            n_below = (i_rd_data.hi <= r_a);
                        end
                    end else if (w_left) begin
                        n_i = r_i + CW'(1);
                    end else if (!w_right) begin
                        n_removed = r_removed + CW'(1);
                        n_gone    = r_gone + f_span(i_rd_data.lo, i_rd_data.hi);
                        if (i_rd_data.lo < r_lo) begin
                            n_lo = i_rd_data.lo;
                        end
                        if (i_rd_data.hi > r_hi) begin
                            n_hi = i_rd_data.hi;
                        end
                    end
                end
                if (w_stop || (!r_pend && (r_k >= r_used))) begin
                    n_pend  = 1'b0;
                    n_state = (r_op == OP_QUERY) ? S_DONE : S_CHECK;
                end
            end
            S_CHECK: begin
                n_pend = 1'b0;
                if (r_removed == '0) begin
                    if (r_used == MAX_CNT) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_cnt   = r_used - r_i;
                        n_k     = r_used - CW'(1);
                        n_up    = 1'b1;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_cnt   = (r_removed == CW'(1)) ? '0 : (r_used - r_i - r_removed);
                    n_k     = r_i + r_removed;
                    n_dm1   = r_removed - CW'(1);
                    n_up    = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_pend = 1'b0;
                if (r_cnt != '0) begin
                    o_rd_en = 1'b1;
                    n_k     = r_up ? (r_k - CW'(1)) : (r_k + CW'(1));
                    n_cnt   = r_cnt - CW'(1);
                    n_pend  = 1'b1;
                    n_pidx  = r_k;
                end
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_dst[IW-1:0];
                    o_wr_data = i_rd_data;
                end
                if ((r_cnt == '0) && !r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_wr_en = 1'b1;
                n_used  = (r_removed == '0) ? (r_used + CW'(1))
                                            : (r_used - r_removed + CW'(1));
                n_total = r_total - r_gone + f_span(r_lo, r_hi);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_total <= n_total;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_a       <= n_a;
        r_am1     <= n_am1;
        r_bp1     <= n_bp1;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_gone    <= n_gone;
        r_k       <= n_k;
        r_pidx    <= n_pidx;
        r_i       <= n_i;
        r_removed <= n_removed;
        r_cnt     <= n_cnt;
        r_dm1     <= n_dm1;
        r_up      <= n_up;
        r_member  <= n_member;
        r_below   <= n_below;
        r_status  <= n_status;
    end

    assign w_count_ext = {7'd0, r_used};

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = '{status:          r_status,
                            is_member:       r_member,
                            all_at_or_below: r_below,
                            interval_count:  w_count_ext[6:0],
                            member_total:    r_total};

endmodule

### rtl/interval_set_merge_table.sv
// ----------------------------------------------------------------------------
// interval_set_merge_table
// Sorted table of disjoint integer intervals with merging insert and query.
// ----------------------------------------------------------------------------
// One item is handled at a time, and every item gives one result beat. The
// table lives in a single-port-read memory and is visited one entry per
// cycle. A query reads every stored interval in turn. An insert scans up to
// the first interval lying beyond the new one, then moves the rest of the
// table by one entry per cycle and writes the merged interval; if no interval
// merges and the table is full, it answers with a full status instead. An
// insert with its start after its end skips the scan and answers with an
// order status. A new item is taken while the previous result still waits in
// the output register.
module interval_set_merge_table #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // low_end[31:0], high_end[63:32]
    input  logic        s_axis_tuser,  // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], is_member[2], all_at_or_below[3], interval_count[10:4],
    // member_total[43:11], zero padding[47:44]
    output logic [47:0] m_axis_tdata
);
    import isms_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    t_entry           w_rd_data;
    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    t_entry           w_wr_data;

    logic             r_m_valid;
    logic [47:0]      r_m_data;

    isms_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .IW            (IW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_low_end    ($signed(s_axis_tdata[31:0])),
        .i_high_end   ($signed(s_axis_tdata[63:32])),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data)
    );

    isms_mem #(
        .DEPTH (MAX_INTERVALS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_data <= {4'd0, w_res.member_total, w_res.interval_count,
                         w_res.all_at_or_below, w_res.is_member, w_res.status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
